// ===== src/stt_pkg.sv =====
// Package for the software timer table: sizes, codes and beat structs.
// No dependencies; every other file of the block uses it by scoped names.
package stt_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int IDX_W = $clog2(MAX_TIMERS);
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [2:0] KIND_EXPIRY = 3'd0;
    localparam logic [2:0] KIND_TICK   = 3'd1;
    localparam logic [2:0] KIND_START  = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_QUERY  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ARG = 2'd1;
    localparam logic [1:0] ST_NO_DEST = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [15:0] TICK_STEP_RESET = 16'd100;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] key;
        logic [7:0]  timer_id;
        logic [30:0] period_ms;
        logic        repeat_mode;
        logic        to_task;
        logic        to_callback;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  status;
        logic [7:0]  expired_id;
        logic [15:0] expired_key;
        logic        notify_task;
        logic        notify_callback;
        logic        present;
        logic        last;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;      // capture the input beat
        logic             clr_ptr;   // reset read and write pointers
        logic             scan_step; // advance read pointer past a non-matching entry
        logic             tick_step; // process entry at read pointer
        logic             rm_step;   // shift entry read pointer+1 down
        logic             append;    // write new entry at count
        logic             set_cnt;   // count <= write pointer
        logic             dec_cnt;
        logic             emit;      // load output register
        logic [2:0]       emit_kind;
        logic [1:0]       emit_status;
        logic             emit_last;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       rd_end;   // read pointer reached the count
        logic       rm_end;   // read pointer+1 reached the count
        logic       hit;      // key found at read pointer
        logic       expire;   // entry at read pointer expires this tick
        logic       full;
        logic       out_busy; // output register holds a beat
        logic [1:0] cmd;
        logic       arg_bad;
        logic       no_dest;
    } sts_t;

endpackage

// ===== src/software_timer_table.sv =====
// Software timer table: up to MAX_TIMERS timers held in table order. Commands
// are tick, start, stop and query; a tick gives one expiry beat per expired
// timer and then a tick-done beat, other commands give one beat. Each command
// walks the table one entry per cycle (a start refused for bad arguments or no
// destination does not walk it, and a tick pauses while an expiry beat waits
// for the output register) and holds the input off until its last beat is
// loaded.
// Depends on stt_pkg, stt_ctrl (with stt_fin) and stt_datapath.
module software_timer_table
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  stt_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output stt_pkg::out_beat_t out_data,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data
);

    stt_pkg::ctl_t ctl;
    stt_pkg::sts_t sts;

    stt_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_ready(out_ready), .sts(sts), .ctl(ctl)
    );

    stt_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .in_beat(in_data), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .ctl(ctl), .sts(sts), .out_beat(out_data),
        .out_valid(out_valid), .out_ready(out_ready)
    );

endmodule

// ===== src/stt_datapath.sv =====
// Datapath of the software timer table: entry store, pointers, output register.
// Depends on stt_pkg.
module stt_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::in_beat_t  in_beat,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  stt_pkg::ctl_t      ctl,
    output stt_pkg::sts_t      sts,
    output stt_pkg::out_beat_t out_beat,
    output logic               out_valid,
    input  logic               out_ready
);

    typedef struct packed {
        logic [15:0] key;
        logic [7:0]  uid;
        logic [31:0] rem;
        logic [30:0] rld;
        logic        rep;
        logic        tt;
        logic        tc;
    } entry_t;

    entry_t                    tab_reg [stt_pkg::MAX_TIMERS];
    stt_pkg::in_beat_t         cur_reg;
    logic [15:0]               step_reg;
    logic [stt_pkg::CNT_W-1:0] cnt_reg;
    logic [stt_pkg::CNT_W-1:0] rd_reg;
    logic [stt_pkg::CNT_W-1:0] wr_reg;
    logic                      ov_reg;
    stt_pkg::out_beat_t        ob_reg;
    stt_pkg::out_beat_t        ob_next;

    entry_t                    ent;
    entry_t                    nxt;
    entry_t                    tick_ent;
    entry_t                    new_ent;
    logic [stt_pkg::CNT_W-1:0] rd_p1;
    logic [31:0]               rem_sub;

    // Entry under the read pointer and its neighbor.
    always_comb
    begin
        rd_p1 = rd_reg + 1'b1;
        ent = tab_reg[rd_reg[stt_pkg::IDX_W-1:0]];
        nxt = tab_reg[rd_p1[stt_pkg::IDX_W-1:0]];
        rem_sub = ent.rem - {16'd0, step_reg};
    end

    assign sts.rd_end = (rd_reg >= cnt_reg);
    assign sts.rm_end = (rd_p1 >= cnt_reg);
    assign sts.hit = (ent.key == cur_reg.key);
    assign sts.expire = (ent.rem <= {16'd0, step_reg});
    assign sts.full = (cnt_reg >= stt_pkg::CNT_W'(stt_pkg::MAX_TIMERS));
    assign sts.out_busy = ov_reg;
    assign sts.cmd = cur_reg.cmd;
    assign sts.arg_bad = (cur_reg.period_ms == 31'd0) || (cur_reg.timer_id == 8'd0);
    assign sts.no_dest = !cur_reg.to_task && !cur_reg.to_callback;

    // Entry written back by a tick, new entry for a start, and the next result beat.
    always_comb
    begin
        tick_ent = ent;
        tick_ent.rem = sts.expire ? {1'b0, ent.rld} : rem_sub;
        new_ent = '{key: cur_reg.key,
            uid: cur_reg.timer_id, rem: {1'b0, cur_reg.period_ms},
            rld: cur_reg.period_ms, rep: cur_reg.repeat_mode,
            tt: cur_reg.to_task, tc: cur_reg.to_callback};
        ob_next = '0;
        ob_next.kind = ctl.emit_kind;
        ob_next.status = ctl.emit_status;
        ob_next.last = ctl.emit_last;
        if (ctl.emit_kind == stt_pkg::KIND_EXPIRY)
        begin
            ob_next.expired_id = ent.uid;
            ob_next.expired_key = ent.key;
            ob_next.notify_task = ent.tt;
            ob_next.notify_callback = ent.tc;
        end
        if (ctl.emit_kind == stt_pkg::KIND_QUERY)
            ob_next.present = !sts.rd_end;
    end

    // Control registers: step, count, pointers and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= stt_pkg::TICK_STEP_RESET;
            cnt_reg <= '0;
            rd_reg <= '0;
            wr_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                step_reg <= cfg_data;
            if (ctl.clr_ptr)
            begin
                rd_reg <= '0;
                wr_reg <= '0;
            end
            else if (ctl.scan_step || ctl.rm_step)
                rd_reg <= rd_p1;
            else if (ctl.tick_step)
            begin
                rd_reg <= rd_p1;
                if (!sts.expire || ent.rep)
                    wr_reg <= wr_reg + 1'b1;
            end
            if (ctl.set_cnt)
                cnt_reg <= wr_reg;
            else if (ctl.append)
                cnt_reg <= cnt_reg + 1'b1;
            else if (ctl.dec_cnt)
                cnt_reg <= cnt_reg - 1'b1;
            if (ctl.emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // Entry store and payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            cur_reg <= in_beat;
        if (ctl.tick_step && (!sts.expire || ent.rep))
            tab_reg[wr_reg[stt_pkg::IDX_W-1:0]] <= tick_ent;
        if (ctl.rm_step)
            tab_reg[rd_reg[stt_pkg::IDX_W-1:0]] <= nxt;
        if (ctl.append)
            tab_reg[cnt_reg[stt_pkg::IDX_W-1:0]] <= new_ent;
        if (ctl.emit)
            ob_reg <= ob_next;
    end

    assign out_valid = ov_reg;
    assign out_beat = ob_reg;

endmodule

// ===== src/stt_ctrl.sv =====
// Controller of the software timer table: sequences scans, ticks and removals.
// Depends on stt_pkg and stt_fin.
module stt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_ready,
    input  stt_pkg::sts_t sts,
    output stt_pkg::ctl_t ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RM   = 3'd3;
    localparam logic [2:0] S_TICK = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic          can_emit;
    logic          in_fin;
    logic [2:0]    kind_reg;
    logic [1:0]    stat_reg;
    stt_pkg::ctl_t ctl_raw;

    assign can_emit = !sts.out_busy || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fin = (state_reg == S_FIN);

    // Next state and commands.
    always_comb
    begin
        ctl_raw = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl_raw.load = 1'b1;
                    ctl_raw.clr_ptr = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.cmd == stt_pkg::CMD_TICK)
                    state_next = S_TICK;
                else if (sts.cmd == stt_pkg::CMD_START && (sts.arg_bad || sts.no_dest))
                begin
                    ctl_raw.emit_kind = stt_pkg::KIND_START;
                    ctl_raw.emit_status = sts.arg_bad ? stt_pkg::ST_BAD_ARG
                                                      : stt_pkg::ST_NO_DEST;
                    state_next = S_FIN;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.rd_end || sts.hit)
                begin
                    ctl_raw.emit_status = stt_pkg::ST_OK;
                    unique case (sts.cmd)
                        stt_pkg::CMD_QUERY: ctl_raw.emit_kind = stt_pkg::KIND_QUERY;
                        stt_pkg::CMD_STOP:  ctl_raw.emit_kind = stt_pkg::KIND_STOP;
                        default:            ctl_raw.emit_kind = stt_pkg::KIND_START;
                    endcase
                    if (sts.cmd == stt_pkg::CMD_QUERY)
                    begin
                        ctl_raw.emit_last = 1'b1;
                        if (can_emit)
                        begin
                            ctl_raw.emit = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else if (!sts.rd_end)
                        state_next = S_RM;
                    else if (sts.cmd == stt_pkg::CMD_START && sts.full)
                    begin
                        ctl_raw.emit_status = stt_pkg::ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ctl_raw.append = (sts.cmd == stt_pkg::CMD_START);
                        state_next = S_FIN;
                    end
                end
                else
                    ctl_raw.scan_step = 1'b1;
            end
            S_RM:
            begin
                ctl_raw.emit_kind = (sts.cmd == stt_pkg::CMD_STOP) ? stt_pkg::KIND_STOP
                                                                : stt_pkg::KIND_START;
                // A restart goes back to the scan, which now ends at once and appends.
                if (sts.rm_end)
                begin
                    ctl_raw.dec_cnt = 1'b1;
                    state_next = (sts.cmd == stt_pkg::CMD_START) ? S_SCAN : S_FIN;
                end
                else
                    ctl_raw.rm_step = 1'b1;
            end
            S_TICK:
            begin
                if (sts.rd_end)
                begin
                    ctl_raw.set_cnt = 1'b1;
                    ctl_raw.emit_kind = stt_pkg::KIND_TICK;
                    state_next = S_FIN;
                end
                else if (!sts.expire)
                    ctl_raw.tick_step = 1'b1;
                else if (can_emit)
                begin
                    ctl_raw.emit = 1'b1;
                    ctl_raw.emit_kind = stt_pkg::KIND_EXPIRY;
                    ctl_raw.tick_step = 1'b1;
                end
            end
            S_FIN:
            begin
                ctl_raw.emit_last = 1'b1;
                if (can_emit)
                begin
                    ctl_raw.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // The kind and status chosen on entry to the final state are held here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg <= stt_pkg::KIND_TICK;
            stat_reg <= stt_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next == S_FIN && state_reg != S_FIN)
            begin
                kind_reg <= ctl_raw.emit_kind;
                stat_reg <= ctl_raw.emit_status;
            end
        end
    end

    // Replace kind and status in the final state by the held values.
    stt_fin u_fin
    (
        .ctl_in(ctl_raw), .fin(in_fin), .kind(kind_reg), .status(stat_reg),
        .ctl_out(ctl)
    );
endmodule

// ===== src/stt_fin.sv =====
// Merges the held kind and status into the controller's commands.
// Depends on stt_pkg.
module stt_fin
(
    input  stt_pkg::ctl_t ctl_in,
    input  logic          fin,
    input  logic [2:0]    kind,
    input  logic [1:0]    status,
    output stt_pkg::ctl_t ctl_out
);
    // In the final state the result code comes from the held registers.
    always_comb
    begin
        ctl_out = ctl_in;
        if (fin)
        begin
            ctl_out.emit_kind = kind;
            ctl_out.emit_status = status;
        end
    end
endmodule

// ===== src/stt_checker.sv =====
// Port-level checks of the software timer table, bound to the top level.
// Depends on stt_pkg and software_timer_table.
module stt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input stt_pkg::out_beat_t out_data
);
    // A held result beat keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result beat changed while stalled");

    // Only expiry beats carry no last flag.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.kind == stt_pkg::KIND_EXPIRY)
        else $error("non-expiry beat without last");

    // An accepted command makes the block busy on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // Expiry beats carry a nonzero id.
    a_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == stt_pkg::KIND_EXPIRY |-> out_data.expired_id != 8'd0)
        else $error("expiry with zero id");
endmodule

bind software_timer_table stt_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/software_timer_table_test.sv =====
// Self-checking testbench for software_timer_table: directed table walk, then
// random commands over several tick steps. Depends on stt_pkg and the RTL.
module software_timer_table_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 3 * stt_pkg::MAX_TIMERS + 12;
    localparam int IN_W = $bits(stt_pkg::in_beat_t);

    typedef struct {
        stt_pkg::in_beat_t  beat;
        bit                 typed;
        stt_pkg::out_beat_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    stt_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_ready = 1'b0;
    stt_pkg::out_beat_t out_data;
    logic               cfg_we;
    logic [15:0]        cfg_data;

    // Shadow copy of the timer table.
    logic [15:0] tmr_key [stt_pkg::MAX_TIMERS];
    logic [7:0]  tmr_id [stt_pkg::MAX_TIMERS];
    logic [31:0] tmr_remaining [stt_pkg::MAX_TIMERS];
    logic [30:0] tmr_reload [stt_pkg::MAX_TIMERS];
    logic        tmr_repeat [stt_pkg::MAX_TIMERS];
    logic        tmr_to_task [stt_pkg::MAX_TIMERS];
    logic        tmr_to_cb [stt_pkg::MAX_TIMERS];
    int          tmr_count;
    logic [15:0] tick_step;

    stt_pkg::out_beat_t pending_beats[$];
    stt_pkg::out_beat_t step_beats[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        items_sent;
    int        expiries_seen = 0;
    int        burst_left;
    int        stall_mode = 0;

    software_timer_table dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic stt_pkg::out_beat_t make_beat(logic [2:0] kind, logic [1:0] status,
                                                     logic [7:0] id, logic [15:0] key,
                                                     logic nt, logic nc, logic pres,
                                                     logic fin);
        stt_pkg::out_beat_t b;
        b.kind = kind;
        b.status = status;
        b.expired_id = id;
        b.expired_key = key;
        b.notify_task = nt;
        b.notify_callback = nc;
        b.present = pres;
        b.last = fin;
        return b;
    endfunction

    function automatic stt_pkg::in_beat_t make_cmd(logic [1:0] cmd, logic [15:0] key,
                                                   logic [7:0] id, logic [30:0] period,
                                                   logic rep, logic tt, logic tc);
        stt_pkg::in_beat_t b;
        b.cmd = cmd;
        b.key = key;
        b.timer_id = id;
        b.period_ms = period;
        b.repeat_mode = rep;
        b.to_task = tt;
        b.to_callback = tc;
        return b;
    endfunction

    // Result beat that carries only a kind, a status and the last flag.
    function automatic stt_pkg::out_beat_t plain_beat(logic [2:0] kind, logic [1:0] status);
        return make_beat(kind, status, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    endfunction

    function automatic int find_timer(logic [15:0] key);
        for (int i = 0; i < tmr_count; i++)
        begin
            if (tmr_key[i] == key)
                return i;
        end
        return tmr_count;
    endfunction

    // Move entry src into slot dst.
    function automatic void copy_timer(int dst, int src);
        tmr_key[dst] = tmr_key[src];
        tmr_id[dst] = tmr_id[src];
        tmr_remaining[dst] = tmr_remaining[src];
        tmr_reload[dst] = tmr_reload[src];
        tmr_repeat[dst] = tmr_repeat[src];
        tmr_to_task[dst] = tmr_to_task[src];
        tmr_to_cb[dst] = tmr_to_cb[src];
    endfunction

    function automatic void drop_timer(int idx);
        for (int i = idx; i + 1 < tmr_count; i++)
            copy_timer(i, i + 1);
        tmr_count--;
    endfunction

    // Computes the result beats of one command and updates the shadow table.
    function automatic void run_timer_cmd(stt_pkg::in_beat_t b);
        int w;
        int idx;
        bit keep;
        logic [1:0] status;
        w = 0;
        step_beats.delete();
        case (b.cmd)
            stt_pkg::CMD_TICK:
            begin
                for (int r = 0; r < tmr_count; r++)
                begin
                    keep = 1'b1;
                    if (tmr_remaining[r] > {16'd0, tick_step})
                        tmr_remaining[r] = tmr_remaining[r] - {16'd0, tick_step};
                    else
                    begin
                        step_beats = {step_beats, make_beat(stt_pkg::KIND_EXPIRY,
                            stt_pkg::ST_OK, tmr_id[r], tmr_key[r], tmr_to_task[r],
                            tmr_to_cb[r], 1'b0, 1'b0)};
                        if (tmr_repeat[r] && tmr_reload[r] != 31'd0)
                            tmr_remaining[r] = {1'b0, tmr_reload[r]};
                        else
                            keep = 1'b0;
                    end
                    if (keep)
                    begin
                        if (w != r)
                            copy_timer(w, r);
                        w++;
                    end
                end
                tmr_count = w;
                step_beats = {step_beats, plain_beat(stt_pkg::KIND_TICK, stt_pkg::ST_OK)};
            end
            stt_pkg::CMD_START:
            begin
                status = stt_pkg::ST_OK;
                if (b.period_ms == 31'd0 || b.timer_id == 8'd0)
                    status = stt_pkg::ST_BAD_ARG;
                else if (!b.to_task && !b.to_callback)
                    status = stt_pkg::ST_NO_DEST;
                else
                begin
                    idx = find_timer(b.key);
                    if (idx < tmr_count)
                        drop_timer(idx);
                    else if (tmr_count >= stt_pkg::MAX_TIMERS)
                        status = stt_pkg::ST_FULL;
                    if (status == stt_pkg::ST_OK)
                    begin
                        tmr_key[tmr_count] = b.key;
                        tmr_id[tmr_count] = b.timer_id;
                        tmr_remaining[tmr_count] = {1'b0, b.period_ms};
                        tmr_reload[tmr_count] = b.period_ms;
                        tmr_repeat[tmr_count] = b.repeat_mode;
                        tmr_to_task[tmr_count] = b.to_task;
                        tmr_to_cb[tmr_count] = b.to_callback;
                        tmr_count++;
                    end
                end
                step_beats = {step_beats, plain_beat(stt_pkg::KIND_START, status)};
            end
            stt_pkg::CMD_STOP:
            begin
                idx = find_timer(b.key);
                if (idx < tmr_count)
                    drop_timer(idx);
                step_beats = {step_beats, plain_beat(stt_pkg::KIND_STOP, stt_pkg::ST_OK)};
            end
            default:
            begin
                idx = find_timer(b.key);
                step_beats = {step_beats, make_beat(stt_pkg::KIND_QUERY, stt_pkg::ST_OK,
                    8'd0, 16'd0, 1'b0, 1'b0, idx < tmr_count, 1'b1)};
            end
        endcase
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    // Drives one beat and waits for it to be taken; senders go idle between bursts at random.
    task automatic send_beat(stt_pkg::in_beat_t b, bit typed = 1'b0,
                             stt_pkg::out_beat_t want = '0);
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        run_timer_cmd(b);
        if (typed)
            pending_beats = {pending_beats, want};
        else
            pending_beats = {pending_beats, step_beats};
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    // Lets the block drain, then writes a new tick step.
    task automatic write_tick_step(logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tick_step = value;
    endtask

    function automatic stt_pkg::in_beat_t random_cmd();
        stt_pkg::in_beat_t b;
        int pick;
        logic [31:0] span;
        pick = $urandom_range(0, 99);
        span = (tick_step == 16'd0) ? 32'd500 : 32'd4 * tick_step;
        b = make_cmd(stt_pkg::CMD_START, 16'($urandom_range(0, 19)),
                     8'($urandom_range(1, 255)), 31'($urandom_range(1, span)),
                     1'($urandom_range(0, 1)), 1'b0, 1'b0);
        b.to_task = 1'($urandom_range(0, 1));
        b.to_callback = b.to_task ? 1'($urandom_range(0, 1)) : 1'b1;
        if ($urandom_range(0, 9) == 0)
            b.key = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            b.period_ms = 31'($urandom);
        if (pick < 10)
            b = stt_pkg::in_beat_t'(IN_W'({$urandom, $urandom}));
        else if (pick < 38)
            b.cmd = stt_pkg::CMD_TICK;
        else if (pick < 53)
            b.cmd = stt_pkg::CMD_STOP;
        else if (pick < 66)
            b.cmd = stt_pkg::CMD_QUERY;
        return b;
    endfunction

    // Receiver stall pattern: always ready, ready at random, or ready one time in four.
    always @(posedge clk)
    begin
        if (cycles % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Result checking against the oldest pending beat.
    always @(posedge clk)
    begin
        stt_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
                report("unexpected beat kind", out_data.kind, 0);
            else
            begin
                want = pending_beats.pop_front();
                if (out_data.kind == stt_pkg::KIND_EXPIRY)
                    expiries_seen++;
                if (out_data.kind !== want.kind)
                    report("kind", out_data.kind, want.kind);
                if (out_data.status !== want.status)
                    report("status", out_data.status, want.status);
                if (out_data.expired_id !== want.expired_id)
                    report("expired_id", out_data.expired_id, want.expired_id);
                if (out_data.expired_key !== want.expired_key)
                    report("expired_key", out_data.expired_key, want.expired_key);
                if (out_data.notify_task !== want.notify_task)
                    report("notify_task", out_data.notify_task, want.notify_task);
                if (out_data.notify_callback !== want.notify_callback)
                    report("notify_callback", out_data.notify_callback,
                           want.notify_callback);
                if (out_data.present !== want.present)
                    report("present", out_data.present, want.present);
                if (out_data.last !== want.last)
                    report("last", out_data.last, want.last);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        stim_row_t rows[$];
        logic [15:0] steps[4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        items_sent = 0;
        burst_left = 4;
        tmr_count = 0;
        tick_step = stt_pkg::TICK_STEP_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: empty table, argument errors, extremes, restart.
        rows = '{
            '{make_cmd(stt_pkg::CMD_QUERY, 16'd5, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0), 1'b1,
              make_beat(stt_pkg::KIND_QUERY, stt_pkg::ST_OK, 8'd0, 16'd0,
                        1'b0, 1'b0, 1'b0, 1'b1)},
            '{make_cmd(stt_pkg::CMD_TICK, 16'd0, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0), 1'b1,
              plain_beat(stt_pkg::KIND_TICK, stt_pkg::ST_OK)},
            '{make_cmd(stt_pkg::CMD_START, 16'd1, 8'd0, 31'd50, 1'b1, 1'b1, 1'b1), 1'b1,
              plain_beat(stt_pkg::KIND_START, stt_pkg::ST_BAD_ARG)},
            '{make_cmd(stt_pkg::CMD_START, 16'd1, 8'd9, 31'd0, 1'b1, 1'b1, 1'b1), 1'b1,
              plain_beat(stt_pkg::KIND_START, stt_pkg::ST_BAD_ARG)},
            '{make_cmd(stt_pkg::CMD_START, 16'd1, 8'd9, 31'd50, 1'b1, 1'b0, 1'b0), 1'b1,
              plain_beat(stt_pkg::KIND_START, stt_pkg::ST_NO_DEST)},
            '{make_cmd(stt_pkg::CMD_START, 16'h0000, 8'hFF, 31'd100, 1'b0, 1'b1, 1'b1),
              1'b1, plain_beat(stt_pkg::KIND_START, stt_pkg::ST_OK)},
            '{make_cmd(stt_pkg::CMD_START, 16'hFFFF, 8'h01, 31'h7FFF_FFFF, 1'b1, 1'b1,
                       1'b0),
              1'b1, plain_beat(stt_pkg::KIND_START, stt_pkg::ST_OK)},
            '{make_cmd(stt_pkg::CMD_START, 16'd3, 8'd2, 31'd150, 1'b1, 1'b0, 1'b1),
              1'b0, '0},
            '{make_cmd(stt_pkg::CMD_START, 16'd3, 8'd4, 31'd250, 1'b1, 1'b0, 1'b1),
              1'b0, '0},
            '{make_cmd(stt_pkg::CMD_QUERY, 16'd3, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0), 1'b0, '0},
            '{make_cmd(stt_pkg::CMD_TICK, 16'd0, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0), 1'b0, '0},
            '{make_cmd(stt_pkg::CMD_TICK, 16'd0, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0), 1'b0, '0},
            '{make_cmd(stt_pkg::CMD_TICK, 16'd0, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0), 1'b0, '0},
            '{make_cmd(stt_pkg::CMD_STOP, 16'd9, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0), 1'b1,
              plain_beat(stt_pkg::KIND_STOP, stt_pkg::ST_OK)},
            '{make_cmd(stt_pkg::CMD_STOP, 16'hFFFF, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0),
              1'b0, '0}
        };
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].typed, rows[i].want);

        // Fill the table past capacity, restart while full, then free a slot.
        for (int i = 0; i < stt_pkg::MAX_TIMERS + 1; i++)
            send_beat(make_cmd(stt_pkg::CMD_START, 16'(16'h0100 + i), 8'(8'h80 + i),
                               31'(300 + i), 1'(i % 2), 1'b1, (i % 3 == 0)));
        send_beat(make_cmd(stt_pkg::CMD_START, 16'h0100, 8'd7, 31'd120, 1'b1, 1'b1, 1'b1));
        send_beat(make_cmd(stt_pkg::CMD_STOP, 16'h0105, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0));
        for (int i = 0; i < 6; i++)
            send_beat(make_cmd(stt_pkg::CMD_TICK, 16'd0, 8'd0, 31'd0, 1'b0, 1'b0, 1'b0));

        // Random phases over several tick steps, extremes and zero among them.
        steps = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535))};
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
                write_tick_step(steps[p - 1]);
            for (int n = 0; n < 56; n++)
                send_beat(random_cmd());
        end

        // Drain.
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_beats.size() != 0)
            report("beats left over", pending_beats.size(), 0);
        $display("sent %0d commands over five tick steps, saw %0d expiry beats",
                 items_sent, expiries_seen);
        $display("%0d mismatches in %0d cycles", mismatches, cycles);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
